// ===== rtl/core/bvs_pkg.sv =====
`timescale 1ns / 1ps

package bvs_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int PRESET_W    = 16;
    localparam int TOTAL_W     = 20;
    localparam int TICK_W      = 8;

    // largest total timer limit: 65535 tenths times ten
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'd655350;

    // command kinds carried with each scan tick
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_MANUAL = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_RESET  = 3'd4;
    localparam logic [2:0] KIND_PARK   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_COMBINED_MODE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_PRESET  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOW_PRESET   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PRESET  = 4'd3;

    // phase codes as reported on the result
    localparam logic [3:0] PHC_IDLE   = 4'd0;
    localparam logic [3:0] PHC_DSTART = 4'd1;
    localparam logic [3:0] PHC_DELAY  = 4'd2;
    localparam logic [3:0] PHC_BSTART = 4'd3;
    localparam logic [3:0] PHC_BLOW   = 4'd4;
    localparam logic [3:0] PHC_HOLD   = 4'd5;
    localparam logic [3:0] PHC_PARK   = 4'd6;
    localparam logic [3:0] PHC_END    = 4'd7;
    localparam logic [3:0] PHC_FIN    = 4'd8;
    localparam logic [3:0] PHC_DONE   = 4'd9;
    localparam logic [3:0] PHC_MAN    = 4'd10;
    localparam logic [3:0] PHC_STOP   = 4'd11;
    localparam logic [3:0] PHC_RST    = 4'd12;

    typedef enum logic [12:0] {
        PH_IDLE   = 13'b0000000000001,
        PH_DSTART = 13'b0000000000010,
        PH_DELAY  = 13'b0000000000100,
        PH_BSTART = 13'b0000000001000,
        PH_BLOW   = 13'b0000000010000,
        PH_HOLD   = 13'b0000000100000,
        PH_PARK   = 13'b0000001000000,
        PH_END    = 13'b0000010000000,
        PH_FIN    = 13'b0000100000000,
        PH_DONE   = 13'b0001000000000,
        PH_MAN    = 13'b0010000000000,
        PH_STOP   = 13'b0100000000000,
        PH_RST    = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TICK_W-1:0] tick_time;
        logic              partner_beyond_setup;
        logic              partner_in_progress;
        logic              partner_total_done;
    } item_t;

    typedef struct packed {
        logic                valve_on;
        logic                action_flag;
        logic [PRESET_W-1:0] shown_delay;
        logic [PRESET_W-1:0] shown_blow;
        logic                request_partner_park;
        logic                request_partner_finish;
        logic [3:0]          phase_code;
        logic                sequence_done;
    } result_t;

    typedef struct packed {
        logic                combined_mode;
        logic [PRESET_W-1:0] delay_preset;
        logic [PRESET_W-1:0] blow_preset;
        logic [PRESET_W-1:0] total_preset;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [PRESET_W-1:0] step_timer;
        logic                step_run;
        logic [PRESET_W-1:0] step_limit;
        logic [TOTAL_W-1:0]  total_timer;
        logic                total_run;
        logic [PRESET_W-1:0] shown_delay;
        logic [PRESET_W-1:0] shown_blow;
        logic                valve;
        logic                act;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        phase:       PH_IDLE,
        step_timer:  '0,
        step_run:    1'b0,
        step_limit:  '0,
        total_timer: '0,
        total_run:   1'b0,
        shown_delay: '0,
        shown_blow:  '0,
        valve:       1'b0,
        act:         1'b0
    };

    function automatic logic [3:0] phase_code(input phase_t p);
        logic [3:0] c;
        case (p)
            PH_IDLE:   c = PHC_IDLE;
            PH_DSTART: c = PHC_DSTART;
            PH_DELAY:  c = PHC_DELAY;
            PH_BSTART: c = PHC_BSTART;
            PH_BLOW:   c = PHC_BLOW;
            PH_HOLD:   c = PHC_HOLD;
            PH_PARK:   c = PHC_PARK;
            PH_END:    c = PHC_END;
            PH_FIN:    c = PHC_FIN;
            PH_DONE:   c = PHC_DONE;
            PH_MAN:    c = PHC_MAN;
            PH_STOP:   c = PHC_STOP;
            PH_RST:    c = PHC_RST;
            default:   c = PHC_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/bvs_if.sv =====
`timescale 1ns / 1ps

interface bvs_item_if;
    logic           valid;
    logic           ready;
    bvs_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bvs_result_if;
    logic             valid;
    logic             ready;
    bvs_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bvs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bvs_pkg::CFG_INDEX_W-1:0]     index;
    logic [bvs_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bvs_cfg_regs.sv =====
`timescale 1ns / 1ps

module bvs_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    bvs_cfg_if.sink           cfg,
    output bvs_pkg::cfg_t     cfg_q
);

    bvs_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bvs_pkg::CFG_COMBINED_MODE: cfg_reg.combined_mode <= cfg.data[0];
                bvs_pkg::CFG_DELAY_PRESET:  cfg_reg.delay_preset  <= cfg.data;
                bvs_pkg::CFG_BLOW_PRESET:   cfg_reg.blow_preset   <= cfg.data;
                bvs_pkg::CFG_TOTAL_PRESET:  cfg_reg.total_preset  <= cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/bvs_seq_step.sv =====
`timescale 1ns / 1ps

module bvs_seq_step (
    input  bvs_pkg::seq_state_t st,
    input  bvs_pkg::cfg_t       cfg,
    input  bvs_pkg::item_t      item,
    output bvs_pkg::seq_state_t nxt,
    output bvs_pkg::result_t    res
);

    logic [bvs_pkg::PRESET_W:0]   step_sum;
    logic [bvs_pkg::PRESET_W-1:0] step_cur;
    logic [bvs_pkg::TOTAL_W-1:0]  total_limit;
    logic [bvs_pkg::TOTAL_W:0]    total_sum;
    logic [bvs_pkg::TOTAL_W-1:0]  total_cur;
    logic                         sq;
    logic                         tq;
    logic                         cmb;
    logic                         ending;
    logic                         req_park;
    logic                         req_fin;
    bvs_pkg::phase_t              ph;

    assign cmb = cfg.combined_mode;

    // saturating on-delay timers; a stopped timer reads zero
    assign step_sum = {1'b0, st.step_timer} + {9'b0, item.tick_time};
    assign step_cur = !st.step_run ? '0 :
                      (step_sum > {1'b0, st.step_limit}) ? st.step_limit
                                                         : step_sum[15:0];

    // preset * 10 as (x << 3) + (x << 1)
    assign total_limit = {1'b0, cfg.total_preset, 3'b0} + {3'b0, cfg.total_preset, 1'b0};
    assign total_sum   = {1'b0, st.total_timer} + {13'b0, item.tick_time};
    assign total_cur   = !st.total_run ? '0 :
                         (total_sum > {1'b0, total_limit}) ? total_limit
                                                           : total_sum[19:0];

    assign sq = st.step_run && (step_cur >= st.step_limit);
    assign tq = st.total_run && (total_cur >= total_limit);
    assign ending = tq || item.partner_total_done;

    always_comb
    begin
        nxt         = st;
        req_park    = 1'b0;
        req_fin     = 1'b0;
        ph          = st.phase;

        case (item.kind)
            bvs_pkg::KIND_START:  ph = bvs_pkg::PH_DSTART;
            bvs_pkg::KIND_MANUAL: ph = bvs_pkg::PH_MAN;
            bvs_pkg::KIND_STOP:   ph = bvs_pkg::PH_STOP;
            bvs_pkg::KIND_RESET:  ph = bvs_pkg::PH_RST;
            bvs_pkg::KIND_PARK:   ph = bvs_pkg::PH_PARK;
            default: ;
        endcase

        nxt.step_timer  = step_cur;
        nxt.total_timer = total_cur;

        case (ph)
            bvs_pkg::PH_IDLE:
            begin
                nxt.valve    = 1'b0;
                nxt.act      = 1'b0;
                nxt.step_run = 1'b0;
            end
            bvs_pkg::PH_DSTART:
            begin
                nxt.total_run = 1'b0;
                if (cfg.delay_preset != '0)
                begin
                    nxt.step_run   = 1'b1;
                    nxt.step_limit = cfg.delay_preset;
                    ph             = bvs_pkg::PH_DELAY;
                end
                else
                begin
                    ph = bvs_pkg::PH_BSTART;
                end
            end
            bvs_pkg::PH_DELAY:
            begin
                nxt.shown_delay = step_cur;
                if (sq)
                begin
                    nxt.step_run = 1'b0;
                    ph           = bvs_pkg::PH_BSTART;
                end
            end
            bvs_pkg::PH_BSTART:
            begin
                if (cmb)
                begin
                    nxt.total_run = 1'b1;
                    req_park      = item.partner_beyond_setup;
                end
                if (cfg.blow_preset != '0)
                begin
                    nxt.step_run   = 1'b1;
                    nxt.step_limit = cfg.blow_preset;
                    ph             = bvs_pkg::PH_BLOW;
                end
                else
                begin
                    ph = cmb ? bvs_pkg::PH_HOLD : bvs_pkg::PH_FIN;
                end
            end
            bvs_pkg::PH_BLOW:
            begin
                nxt.valve      = 1'b1;
                nxt.act        = 1'b1;
                nxt.shown_blow = step_cur;
                if (sq)
                begin
                    nxt.valve    = 1'b0;
                    nxt.step_run = 1'b0;
                    ph           = cmb ? bvs_pkg::PH_HOLD : bvs_pkg::PH_FIN;
                end
                // a total-time end, own or the partner's, overrides the blow-done move
                if (cmb && ending)
                begin
                    nxt.valve     = 1'b0;
                    nxt.total_run = 1'b0;
                    ph            = bvs_pkg::PH_END;
                end
            end
            bvs_pkg::PH_HOLD:
            begin
                if (cmb)
                begin
                    nxt.valve = 1'b1;
                    nxt.act   = 1'b1;
                    if (ending)
                    begin
                        nxt.valve     = 1'b0;
                        nxt.total_run = 1'b0;
                        ph            = bvs_pkg::PH_END;
                    end
                end
            end
            bvs_pkg::PH_PARK:
            begin
                if (cmb)
                begin
                    nxt.valve = 1'b0;
                end
            end
            bvs_pkg::PH_END:
            begin
                if (cmb)
                begin
                    req_fin       = item.partner_in_progress;
                    nxt.valve     = 1'b0;
                    nxt.step_run  = 1'b0;
                    nxt.total_run = 1'b0;
                    ph            = bvs_pkg::PH_FIN;
                end
            end
            bvs_pkg::PH_FIN:
            begin
                nxt.valve    = 1'b0;
                nxt.step_run = 1'b0;
                nxt.act      = 1'b0;
                ph           = bvs_pkg::PH_DONE;
            end
            bvs_pkg::PH_MAN:
            begin
                if (cmb)
                begin
                    nxt.valve = 1'b1;
                    nxt.act   = 1'b1;
                end
            end
            bvs_pkg::PH_STOP,
            bvs_pkg::PH_RST:
            begin
                nxt.valve     = 1'b0;
                nxt.step_run  = 1'b0;
                nxt.total_run = 1'b0;
                nxt.act       = 1'b0;
                ph            = bvs_pkg::PH_IDLE;
            end
            default: ;
        endcase

        nxt.phase = ph;

        res.valve_on               = nxt.valve;
        res.action_flag            = nxt.act;
        res.shown_delay            = nxt.shown_delay;
        res.shown_blow             = nxt.shown_blow;
        res.request_partner_park   = req_park;
        res.request_partner_finish = req_fin;
        res.phase_code             = bvs_pkg::phase_code(ph);
        res.sequence_done          = (ph == bvs_pkg::PH_DONE);
    end

endmodule

// ===== rtl/core/blow_valve_sequencer_core.sv =====
`timescale 1ns / 1ps

// Blow valve sequencer: every request on the item channel is one scan tick that
// may carry a command, and gives exactly one result. The phase step and both
// saturating timer adds run in one pass of logic from the sequencer state
// registers into the result register, so a request is taken every unstalled
// cycle and its result appears in the cycle after acceptance. The result
// register decouples the two sides: a new request is taken whenever the result
// register is empty or is being drained in the same cycle. Configuration writes
// are taken in any cycle and must only be issued while no result is outstanding.
module blow_valve_sequencer_core (
    input  logic            clk,
    input  logic            rst_n,
    bvs_item_if.sink        item,
    bvs_result_if.source    result,
    bvs_cfg_if.sink         cfg
);

    bvs_pkg::cfg_t          cfg_q;
    bvs_pkg::seq_state_t    state_reg;
    bvs_pkg::seq_state_t    state_next;
    bvs_pkg::result_t       res_next;
    bvs_pkg::result_t       res_reg;
    logic                   res_valid_reg;
    logic                   item_acc;

    bvs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    bvs_seq_step u_step (
        .st   (state_reg),
        .cfg  (cfg_q),
        .item (item.data),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign item.ready   = !res_valid_reg || result.ready;
    assign item_acc     = item.valid && item.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bvs_pkg::SEQ_STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else if (item_acc)
        begin
            state_reg     <= state_next;
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            res_reg <= res_next;
        end
    end

    a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> res_valid_reg)
        else $error("accepted request produced no result");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.total_timer <= bvs_pkg::TOTAL_MAX)
        else $error("total timer beyond largest limit");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |->
            (res_reg.sequence_done == (res_reg.phase_code == bvs_pkg::PHC_DONE)))
        else $error("sequence_done disagrees with phase code");

    a_park_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.request_partner_park) |->
            (res_reg.phase_code == bvs_pkg::PHC_BLOW ||
             res_reg.phase_code == bvs_pkg::PHC_HOLD))
        else $error("park request outside blow start");

    a_fin_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.request_partner_finish) |->
            (res_reg.phase_code == bvs_pkg::PHC_FIN))
        else $error("finish request outside ending");

endmodule

// ===== sim/blow_valve_sequencer_core_tb.sv =====
`timescale 1ns / 1ps

module blow_valve_sequencer_core_tb;

    // kinds with no command, treated as plain scan ticks
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int         PHASE_COUNT  = 16;
    localparam int         PHASE_ITEMS  = 100;

    typedef struct {
        bit                              is_reg;
        logic [bvs_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [bvs_pkg::CFG_DATA_W-1:0]  reg_value;
        bvs_pkg::item_t                  tick_item;
        bit                              typed;
        bvs_pkg::result_t                typed_result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bvs_item_if   item_ch ();
    bvs_result_if result_ch ();
    bvs_cfg_if    cfg_ch ();

    blow_valve_sequencer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // sequencer copy used for prediction
    bvs_pkg::cfg_t                seq_cfg;
    logic [3:0]                   seq_phase;
    logic [bvs_pkg::PRESET_W-1:0] step_count;
    logic [bvs_pkg::PRESET_W-1:0] step_limit;
    logic                         step_running;
    logic [bvs_pkg::TOTAL_W-1:0]  total_count;
    logic                         total_running;
    logic [bvs_pkg::PRESET_W-1:0] disp_delay;
    logic [bvs_pkg::PRESET_W-1:0] disp_blow;
    logic                         valve_latch;
    logic                         action_latch;

    bvs_pkg::result_t pending_results[$];
    stim_row_t        stim_table[$];
    bit               no_idle;
    int               err_count;
    int               ticks_sent;
    int               results_seen;
    int               reg_writes;
    int               park_reqs;
    int               finish_reqs;
    logic [15:0]      phases_seen;

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic bvs_pkg::result_t advance_sequencer(input bvs_pkg::item_t it);
        bvs_pkg::result_t             r;
        logic [bvs_pkg::PRESET_W:0]   step_sum;
        logic [bvs_pkg::TOTAL_W:0]    total_sum;
        logic [bvs_pkg::TOTAL_W-1:0]  total_lim;
        logic                         step_done;
        logic                         total_done;
        logic                         cmb;
        logic                         park_req;
        logic                         fin_req;

        cmb      = seq_cfg.combined_mode;
        park_req = 1'b0;
        fin_req  = 1'b0;

        case (it.kind)
            bvs_pkg::KIND_START:  seq_phase = bvs_pkg::PHC_DSTART;
            bvs_pkg::KIND_MANUAL: seq_phase = bvs_pkg::PHC_MAN;
            bvs_pkg::KIND_STOP:   seq_phase = bvs_pkg::PHC_STOP;
            bvs_pkg::KIND_RESET:  seq_phase = bvs_pkg::PHC_RST;
            bvs_pkg::KIND_PARK:   seq_phase = bvs_pkg::PHC_PARK;
            default:     ;
        endcase

        // timers advance with the run flags left by the previous tick
        if (step_running) begin
            step_sum   = {1'b0, step_count} + it.tick_time;
            step_count = (step_sum > step_limit) ? step_limit
                                                 : step_sum[bvs_pkg::PRESET_W-1:0];
        end else begin
            step_count = '0;
        end
        total_lim = bvs_pkg::TOTAL_W'(seq_cfg.total_preset * 10);
        if (total_running) begin
            total_sum   = {1'b0, total_count} + it.tick_time;
            total_count = (total_sum > total_lim) ? total_lim
                                                  : total_sum[bvs_pkg::TOTAL_W-1:0];
        end else begin
            total_count = '0;
        end
        step_done  = step_running && (step_count >= step_limit);
        total_done = total_running && (total_count >= total_lim);

        case (seq_phase)
            bvs_pkg::PHC_IDLE:
            begin
                valve_latch  = 1'b0;
                action_latch = 1'b0;
                step_running = 1'b0;
            end
            bvs_pkg::PHC_DSTART:
            begin
                total_running = 1'b0;
                if (seq_cfg.delay_preset != 0) begin
                    step_running = 1'b1;
                    step_limit   = seq_cfg.delay_preset;
                    seq_phase    = bvs_pkg::PHC_DELAY;
                end else begin
                    seq_phase = bvs_pkg::PHC_BSTART;
                end
            end
            bvs_pkg::PHC_DELAY:
            begin
                disp_delay = step_count;
                if (step_done) begin
                    step_running = 1'b0;
                    seq_phase    = bvs_pkg::PHC_BSTART;
                end
            end
            bvs_pkg::PHC_BSTART:
            begin
                if (cmb) begin
                    total_running = 1'b1;
                    park_req      = it.partner_beyond_setup;
                end
                if (seq_cfg.blow_preset != 0) begin
                    step_running = 1'b1;
                    step_limit   = seq_cfg.blow_preset;
                    seq_phase    = bvs_pkg::PHC_BLOW;
                end else begin
                    seq_phase = cmb ? bvs_pkg::PHC_HOLD : bvs_pkg::PHC_FIN;
                end
            end
            bvs_pkg::PHC_BLOW:
            begin
                valve_latch  = 1'b1;
                action_latch = 1'b1;
                disp_blow    = step_count;
                if (step_done) begin
                    valve_latch  = 1'b0;
                    step_running = 1'b0;
                    seq_phase    = cmb ? bvs_pkg::PHC_HOLD : bvs_pkg::PHC_FIN;
                end
                // total time or partner ending cuts the timed blow short
                if (cmb && (total_done || it.partner_total_done)) begin
                    valve_latch   = 1'b0;
                    total_running = 1'b0;
                    seq_phase     = bvs_pkg::PHC_END;
                end
            end
            bvs_pkg::PHC_HOLD:
            begin
                if (cmb) begin
                    valve_latch  = 1'b1;
                    action_latch = 1'b1;
                    if (total_done || it.partner_total_done) begin
                        valve_latch   = 1'b0;
                        total_running = 1'b0;
                        seq_phase     = bvs_pkg::PHC_END;
                    end
                end
            end
            bvs_pkg::PHC_PARK:
            begin
                if (cmb)
                    valve_latch = 1'b0;
            end
            bvs_pkg::PHC_END:
            begin
                if (cmb) begin
                    fin_req       = it.partner_in_progress;
                    valve_latch   = 1'b0;
                    step_running  = 1'b0;
                    total_running = 1'b0;
                    seq_phase     = bvs_pkg::PHC_FIN;
                end
            end
            bvs_pkg::PHC_FIN:
            begin
                valve_latch  = 1'b0;
                step_running = 1'b0;
                action_latch = 1'b0;
                seq_phase    = bvs_pkg::PHC_DONE;
            end
            bvs_pkg::PHC_MAN:
            begin
                if (cmb) begin
                    valve_latch  = 1'b1;
                    action_latch = 1'b1;
                end
            end
            bvs_pkg::PHC_STOP, bvs_pkg::PHC_RST:
            begin
                valve_latch   = 1'b0;
                step_running  = 1'b0;
                total_running = 1'b0;
                action_latch  = 1'b0;
                seq_phase     = bvs_pkg::PHC_IDLE;
            end
            default: ;
        endcase

        r.valve_on               = valve_latch;
        r.action_flag            = action_latch;
        r.shown_delay            = disp_delay;
        r.shown_blow             = disp_blow;
        r.request_partner_park   = park_req;
        r.request_partner_finish = fin_req;
        r.phase_code             = seq_phase;
        r.sequence_done          = (seq_phase == bvs_pkg::PHC_DONE);
        return r;
    endfunction

    function automatic bvs_pkg::item_t make_tick(input logic [2:0] kind,
                                                 input logic [7:0] tick,
                                                 input logic [2:0] partner);
        bvs_pkg::item_t it;
        it.kind                 = kind;
        it.tick_time            = tick;
        it.partner_beyond_setup = partner[2];
        it.partner_in_progress  = partner[1];
        it.partner_total_done   = partner[0];
        return it;
    endfunction

    function automatic stim_row_t row_tick(input logic [2:0] kind, input logic [7:0] tick,
                                           input logic [2:0] partner);
        stim_row_t row;
        row           = '{default: '0};
        row.tick_item = make_tick(kind, tick, partner);
        return row;
    endfunction

    // quiet result: valve off, nothing shown, no partner requests
    function automatic stim_row_t row_typed(input logic [2:0] kind, input logic [7:0] tick,
                                            input logic [2:0] partner, input logic [3:0] ph);
        stim_row_t row;
        row                         = row_tick(kind, tick, partner);
        row.typed                   = 1'b1;
        row.typed_result            = '0;
        row.typed_result.phase_code = ph;
        row.typed_result.sequence_done = (ph == bvs_pkg::PHC_DONE);
        return row;
    endfunction

    function automatic stim_row_t row_reg(input logic [bvs_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [bvs_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row;
        row           = '{default: '0};
        row.is_reg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic logic [bvs_pkg::PRESET_W-1:0] pick_preset(input int small_max);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return bvs_pkg::PRESET_W'($urandom);
            default: return bvs_pkg::PRESET_W'($urandom_range(small_max, 1));
        endcase
    endfunction

    task automatic send_tick(input bvs_pkg::item_t it, input bit typed,
                             input bvs_pkg::result_t typed_result);
        bvs_pkg::result_t predicted;
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 27) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        forever begin
            @(posedge clk);
            if (item_ch.ready)
                break;
        end
        predicted = advance_sequencer(it);
        pending_results.push_back(typed ? typed_result : predicted);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [bvs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bvs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        forever begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        case (idx)
            bvs_pkg::CFG_COMBINED_MODE: seq_cfg.combined_mode = value[0];
            bvs_pkg::CFG_DELAY_PRESET:  seq_cfg.delay_preset  = value;
            bvs_pkg::CFG_BLOW_PRESET:   seq_cfg.blow_preset   = value;
            bvs_pkg::CFG_TOTAL_PRESET:  seq_cfg.total_preset  = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // drop the request line and let every outstanding result drain
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic check_result(input bvs_pkg::result_t want, input bvs_pkg::result_t got);
        if (got.valve_on !== want.valve_on) begin
            $error("valve_on: expected %0d, got %0d", want.valve_on, got.valve_on);
            err_count++;
        end
        if (got.action_flag !== want.action_flag) begin
            $error("action_flag: expected %0d, got %0d", want.action_flag, got.action_flag);
            err_count++;
        end
        if (got.shown_delay !== want.shown_delay) begin
            $error("shown_delay: expected %0d, got %0d", want.shown_delay, got.shown_delay);
            err_count++;
        end
        if (got.shown_blow !== want.shown_blow) begin
            $error("shown_blow: expected %0d, got %0d", want.shown_blow, got.shown_blow);
            err_count++;
        end
        if (got.request_partner_park !== want.request_partner_park) begin
            $error("request_partner_park: expected %0d, got %0d",
                   want.request_partner_park, got.request_partner_park);
            err_count++;
        end
        if (got.request_partner_finish !== want.request_partner_finish) begin
            $error("request_partner_finish: expected %0d, got %0d",
                   want.request_partner_finish, got.request_partner_finish);
            err_count++;
        end
        if (got.phase_code !== want.phase_code) begin
            $error("phase_code: expected %0d, got %0d", want.phase_code, got.phase_code);
            err_count++;
        end
        if (got.sequence_done !== want.sequence_done) begin
            $error("sequence_done: expected %0d, got %0d", want.sequence_done, got.sequence_done);
            err_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result arrived with nothing outstanding");
                err_count++;
            end else begin
                check_result(pending_results.pop_front(), result_ch.data);
            end
            results_seen++;
            park_reqs   += result_ch.data.request_partner_park;
            finish_reqs += result_ch.data.request_partner_finish;
            phases_seen[result_ch.data.phase_code] = 1'b1;
        end
    end

    always @(negedge clk) begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= 27);
    end

    initial begin
        #10_000_000;
        $error("run timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        bvs_pkg::item_t                it;
        logic [2:0]                    kind;
        logic [7:0]                    tick;
        int                            pick;
        logic                          mode;
        logic [bvs_pkg::PRESET_W-1:0]  dly;
        logic [bvs_pkg::PRESET_W-1:0]  blw;
        logic [bvs_pkg::PRESET_W-1:0]  tot;

        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        no_idle         = 1'b0;
        err_count       = 0;
        ticks_sent      = 0;
        results_seen    = 0;
        reg_writes      = 0;
        park_reqs       = 0;
        finish_reqs     = 0;
        phases_seen     = '0;

        seq_cfg       = '0;
        seq_phase     = bvs_pkg::PHC_IDLE;
        step_count    = '0;
        step_limit    = '0;
        step_running  = 1'b0;
        total_count   = '0;
        total_running = 1'b0;
        disp_delay    = '0;
        disp_blow     = '0;
        valve_latch   = 1'b0;
        action_latch  = 1'b0;

        // standard mode, all presets zero: the sequence falls straight through
        stim_table.push_back(row_typed(bvs_pkg::KIND_TICK,   8'd0,   3'b000,
                                       bvs_pkg::PHC_IDLE));
        stim_table.push_back(row_typed(bvs_pkg::KIND_TICK,   8'd255, 3'b111,
                                       bvs_pkg::PHC_IDLE));
        stim_table.push_back(row_typed(bvs_pkg::KIND_START,  8'd0,   3'b100,
                                       bvs_pkg::PHC_BSTART));
        stim_table.push_back(row_typed(bvs_pkg::KIND_TICK,   8'd17,  3'b000,
                                       bvs_pkg::PHC_FIN));
        stim_table.push_back(row_typed(bvs_pkg::KIND_TICK,   8'd0,   3'b000,
                                       bvs_pkg::PHC_DONE));
        stim_table.push_back(row_typed(bvs_pkg::KIND_MANUAL, 8'd1,   3'b000,
                                       bvs_pkg::PHC_MAN));
        stim_table.push_back(row_typed(bvs_pkg::KIND_PARK,   8'd2,   3'b000,
                                       bvs_pkg::PHC_PARK));
        stim_table.push_back(row_typed(bvs_pkg::KIND_STOP,   8'd3,   3'b000,
                                       bvs_pkg::PHC_IDLE));
        stim_table.push_back(row_typed(bvs_pkg::KIND_RESET,  8'd0,   3'b111,
                                       bvs_pkg::PHC_IDLE));
        stim_table.push_back(row_tick(KIND_SPARE_A, 8'd9,   3'b010));
        stim_table.push_back(row_tick(KIND_SPARE_B, 8'd4,   3'b101));
        // combined mode, short presets: delay, park request, blow cut by partner
        stim_table.push_back(row_reg(bvs_pkg::CFG_COMBINED_MODE, 16'd1));
        stim_table.push_back(row_reg(bvs_pkg::CFG_DELAY_PRESET,  16'd3));
        stim_table.push_back(row_reg(bvs_pkg::CFG_BLOW_PRESET,   16'd5));
        stim_table.push_back(row_reg(bvs_pkg::CFG_TOTAL_PRESET,  16'd2));
        stim_table.push_back(row_tick(bvs_pkg::KIND_START,  8'd0,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd2,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd255, 3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd0,   3'b100));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd3,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd1,   3'b001));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd0,   3'b010));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd0,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_MANUAL, 8'd0,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_PARK,   8'd8,   3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_RESET,  8'd0,   3'b000));
        // largest presets with largest ticks
        stim_table.push_back(row_reg(bvs_pkg::CFG_DELAY_PRESET,  16'hFFFF));
        stim_table.push_back(row_reg(bvs_pkg::CFG_BLOW_PRESET,   16'hFFFF));
        stim_table.push_back(row_reg(bvs_pkg::CFG_TOTAL_PRESET,  16'hFFFF));
        stim_table.push_back(row_tick(bvs_pkg::KIND_START,  8'd255, 3'b111));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd255, 3'b000));
        stim_table.push_back(row_tick(bvs_pkg::KIND_STOP,   8'd0,   3'b000));
        // no delay, no timed blow: straight into hold
        stim_table.push_back(row_reg(bvs_pkg::CFG_DELAY_PRESET,  16'd0));
        stim_table.push_back(row_reg(bvs_pkg::CFG_BLOW_PRESET,   16'd0));
        stim_table.push_back(row_tick(bvs_pkg::KIND_START,  8'd0,   3'b100));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd0,   3'b001));
        stim_table.push_back(row_tick(bvs_pkg::KIND_TICK,   8'd0,   3'b010));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].is_reg) begin
                settle();
                write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
            end else begin
                send_tick(stim_table[i].tick_item, stim_table[i].typed,
                          stim_table[i].typed_result);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            case (p)
                0: begin mode = 1'b1; dly = '1; blw = '1; tot = '1; end
                1: begin mode = 1'b0; dly = '0; blw = '0; tot = '0; end
                default:
                begin
                    mode = 1'($urandom_range(1));
                    dly  = pick_preset(40);
                    blw  = pick_preset(60);
                    tot  = pick_preset(30);
                end
            endcase
            write_reg(bvs_pkg::CFG_COMBINED_MODE, {15'd0, mode});
            write_reg(bvs_pkg::CFG_DELAY_PRESET, dly);
            write_reg(bvs_pkg::CFG_BLOW_PRESET, blw);
            write_reg(bvs_pkg::CFG_TOTAL_PRESET, tot);
            no_idle = (p >= 5 && p < 8);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (n == 0 || pick < 4)
                    kind = bvs_pkg::KIND_START;
                else if (pick < 6)
                    kind = bvs_pkg::KIND_MANUAL;
                else if (pick < 8)
                    kind = bvs_pkg::KIND_STOP;
                else if (pick < 10)
                    kind = bvs_pkg::KIND_RESET;
                else if (pick < 12)
                    kind = bvs_pkg::KIND_PARK;
                else if (pick < 14)
                    kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
                else
                    kind = bvs_pkg::KIND_TICK;
                case ($urandom_range(9))
                    0:          tick = $urandom_range(1) ? 8'd255 : 8'd0;
                    1, 2, 3, 4: tick = 8'($urandom_range(255));
                    default:    tick = 8'($urandom_range(15));
                endcase
                it = make_tick(kind, tick, {1'($urandom_range(1)), 1'($urandom_range(1)),
                                            1'($urandom_range(9) == 0)});
                send_tick(it, 1'b0, '0);
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Run covered %0d scan ticks with %0d register writes; %0d results checked.",
                 ticks_sent, reg_writes, results_seen);
        $display("Partner park requests %0d, finish requests %0d, phase codes seen %013b.",
                 park_reqs, finish_reqs, phases_seen[12:0]);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
